[rtl/csst_pkg.sv]
// Package for the cursor sequence store: item types, operation codes and the
// shift commands that the control logic broadcasts to the row of entry cells.
// No dependencies.
package csst_pkg;

  // Operation carried by an input item.
  typedef enum logic [3:0] {
    KIND_START    = 4'd0,
    KIND_END      = 4'd1,
    KIND_ADVANCE  = 4'd2,
    KIND_RETREAT  = 4'd3,
    KIND_INSERT   = 4'd4,
    KIND_ATTACH   = 4'd5,
    KIND_REMOVE   = 4'd6,
    KIND_INSFRONT = 4'd7,
    KIND_ATTBACK  = 4'd8,
    KIND_REMFRONT = 4'd9,
    KIND_READCUR  = 4'd10,
    KIND_READIDX  = 4'd11
  } csst_kind_e;

  // Shift command seen by every entry cell.
  typedef enum logic [1:0] {
    SHIFT_NONE   = 2'd0,
    SHIFT_INSERT = 2'd1,
    SHIFT_REMOVE = 2'd2
  } csst_shift_e;

  // Input item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] entry_value;
    logic [5:0]  read_index;
  } csst_in_t;

  // Result item.
  typedef struct packed {
    logic [31:0] read_value;
    logic        has_item;
    logic [5:0]  count;
    logic [5:0]  cursor_pos;
    logic        error;
  } csst_out_t;

endpackage

[rtl/csst_cell.sv]
// One entry cell of the cursor sequence store. It holds one word and, on a
// shift command, loads the new word or takes its left or right neighbor.
// Depends on csst_pkg.
module csst_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_WIDTH  = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk_i,
  input  csst_pkg::csst_shift_e shift_i,
  input  logic [IDX_WIDTH-1:0]  pos_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(CELL_INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Insert: the cell at the position loads the word, cells above it take
  // their left neighbor. Remove: the cell at the position and those above
  // it take their right neighbor.
  always_comb begin
    data_d = data_q;
    case (shift_i)
      csst_pkg::SHIFT_INSERT: begin
        if (MyIdx == pos_i) begin
          data_d = word_i;
        end else if (MyIdx > pos_i) begin
          data_d = left_i;
        end
      end
      csst_pkg::SHIFT_REMOVE: begin
        if (MyIdx >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/cursor_sequence_store_core.sv]
// Top level of the cursor sequence store: cursor and count control, the row
// of entry cells and the registered result item.
// Depends on csst_pkg and csst_cell.
//
//   channel | direction | payload     | accepted when
//   --------+-----------+-------------+------------------------------
//   in      | input     | csst_in_t   | in_valid_i && in_ready_o
//   out     | output    | csst_out_t  | out_valid_o && out_ready_i
//
// Every operation, shifts included, completes when its item is taken: all entry cells
// move in parallel, so an item's result is registered at the edge that takes it.
// One item per cycle is sustained while the output side takes results; a
// stalled result blocks new items only until it is taken.
// Reset clears count, cursor and the output valid; entry words are not reset
// and are never read before they are written.
module cursor_sequence_store_core #(
  parameter int CAPACITY_WORDS = 32,
  parameter int DATA_WIDTH     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csst_pkg::csst_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csst_pkg::csst_out_t out_item_o
);

  localparam int CntW = $clog2(CAPACITY_WORDS + 1);
  localparam int IdxW = (CAPACITY_WORDS > 1) ? $clog2(CAPACITY_WORDS) : 1;
  localparam int CmpW = (CntW > 6) ? CntW : 6;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY_WORDS);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cur_q, cur_d;
  logic            out_valid_q;
  csst_pkg::csst_out_t out_q;

  logic                  in_fire;
  logic                  item;
  logic                  full;
  logic                  err_d;
  logic [DATA_WIDTH-1:0] rd_d;
  logic [DATA_WIDTH-1:0] word;
  logic [CntW-1:0]       pos_c;
  logic [CmpW-1:0]       idx_ext;
  csst_pkg::csst_shift_e shift_d;
  csst_pkg::csst_shift_e shift_cell;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY_WORDS];
  logic [DATA_WIDTH-1:0] left_w    [CAPACITY_WORDS];
  logic [DATA_WIDTH-1:0] right_w   [CAPACITY_WORDS];

  // Handshake: a new item is taken once the result register is free.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign item    = cur_q < cnt_q;
  assign full    = cnt_q >= CapCnt;
  assign word    = DATA_WIDTH'(in_item_i.entry_value);
  assign idx_ext = CmpW'(in_item_i.read_index);

  // Operation decode: cursor, count, shift command and read data.
  always_comb begin
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    shift_d = csst_pkg::SHIFT_NONE;
    pos_c   = '0;
    rd_d    = '0;
    err_d   = 1'b0;
    case (in_item_i.kind)
      csst_pkg::KIND_START: cur_d = '0;
      csst_pkg::KIND_END: cur_d = (cnt_q != '0) ? cnt_q - CntW'(1) : '0;
      csst_pkg::KIND_ADVANCE: begin
        if (item) begin
          cur_d = cur_q + CntW'(1);
        end
      end
      csst_pkg::KIND_RETREAT: begin
        if (cur_q != '0) begin
          cur_d = cur_q - CntW'(1);
        end
      end
      csst_pkg::KIND_INSERT, csst_pkg::KIND_ATTACH,
      csst_pkg::KIND_INSFRONT, csst_pkg::KIND_ATTBACK: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          case (in_item_i.kind)
            csst_pkg::KIND_INSERT:  pos_c = item ? cur_q : '0;
            csst_pkg::KIND_ATTACH:  pos_c = item ? cur_q + CntW'(1) : cnt_q;
            csst_pkg::KIND_ATTBACK: pos_c = cnt_q;
            default:                pos_c = '0;
          endcase
          cur_d   = pos_c;
          cnt_d   = cnt_q + CntW'(1);
          shift_d = csst_pkg::SHIFT_INSERT;
        end
      end
      csst_pkg::KIND_REMOVE: begin
        if (!item) begin
          err_d = 1'b1;
        end else begin
          pos_c   = cur_q;
          cnt_d   = cnt_q - CntW'(1);
          shift_d = csst_pkg::SHIFT_REMOVE;
        end
      end
      csst_pkg::KIND_REMFRONT: begin
        if (cnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          cur_d   = '0;
          cnt_d   = cnt_q - CntW'(1);
          shift_d = csst_pkg::SHIFT_REMOVE;
        end
      end
      csst_pkg::KIND_READCUR: begin
        if (!item) begin
          err_d = 1'b1;
        end else begin
          rd_d = cell_data[cur_q[IdxW-1:0]];
        end
      end
      csst_pkg::KIND_READIDX: begin
        if (idx_ext >= CmpW'(cnt_q)) begin
          err_d = 1'b1;
        end else begin
          rd_d = cell_data[idx_ext[IdxW-1:0]];
        end
      end
      default: ;
    endcase
  end

  assign shift_cell = in_fire ? shift_d : csst_pkg::SHIFT_NONE;

  // Row of entry cells, each wired to its two neighbors.
  for (genvar i = 0; i < CAPACITY_WORDS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = cell_data[i-1];
    end
    if (i == CAPACITY_WORDS - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_mid_r
      assign right_w[i] = cell_data[i+1];
    end

    csst_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX_WIDTH (IdxW),
      .CELL_INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_cell),
      .pos_i  (pos_c[IdxW-1:0]),
      .word_i (word),
      .left_i (left_w[i]),
      .right_i(right_w[i]),
      .data_o (cell_data[i])
    );
  end

  // Cursor, count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= cnt_d;
        cur_q <= cur_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.read_value <= 32'(rd_d);
      out_q.has_item   <= cur_d < cnt_d;
      out_q.count      <= 6'(cnt_d);
      out_q.cursor_pos <= 6'(cur_d);
      out_q.error      <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The cursor never passes the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= cnt_q)
    else $error("cursor beyond entry count");

  // The entry count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CapCnt)
    else $error("entry count beyond capacity");

  // A failed operation leaves cursor and count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && err_d) |=> (cnt_q == $past(cnt_q) && cur_q == $past(cur_q)))
    else $error("failed operation changed state");

  // A failed operation never shifts the cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_d |-> (shift_d == csst_pkg::SHIFT_NONE))
    else $error("shift issued on failed operation");

  // Every accepted item raises the result valid at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule
